// File: rtl/core/rdq_pkg.sv
// Shared types, codes and constants of the record deque with key search.
package rdq_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int CMD_W     = 3;
    localparam int KEY_W     = 32;
    localparam int PAY_W     = 32;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 5;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SEARCH     = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } rec_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_SEARCH
    } state_t;

endpackage

// File: rtl/core/rdq_store.sv
// Record memory of the deque: one write port and one registered read port.
module rdq_store #(
    parameter int DEPTH = rdq_pkg::DEPTH_DEFAULT,
    localparam int IW = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [IW-1:0]     wr_addr,
    input  rdq_pkg::rec_t     wr_data,
    input  logic              rd_en,
    input  logic [IW-1:0]     rd_addr,
    output rdq_pkg::rec_t     rd_data
);

    rdq_pkg::rec_t mem [DEPTH];
    rdq_pkg::rec_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/record_deque_with_key_search_core.sv
// Top level of the record deque with key search, built around one record memory.
// Push, rejected push, empty pop or search and unused codes: done in the cycle after start.
// Pop: S_POP takes the record from the registered memory read and then raises done.
// Search: one memory read per held record from the front, done early on a hit.
// A new command may start while done is high; busy is high only in S_POP and S_SEARCH.
// Reset clears the front index, the record count and the results; memory contents stay.
module record_deque_with_key_search_core #(
    parameter int DEPTH = rdq_pkg::DEPTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [rdq_pkg::CMD_W-1:0]     cmd,
    input  logic [rdq_pkg::KEY_W-1:0]     key,
    input  logic [rdq_pkg::PAY_W-1:0]     payload,
    output logic                          done,
    output logic [rdq_pkg::STATUS_W-1:0]  status,
    output logic                          found,
    output logic [rdq_pkg::KEY_W-1:0]     key_out,
    output logic [rdq_pkg::PAY_W-1:0]     payload_out,
    output logic [rdq_pkg::COUNT_W-1:0]   count
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [IW:0]   DEPTH_W = (IW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    rdq_pkg::state_t state_reg, state_next;
    logic [IW-1:0] front_reg, front_next;
    logic [CW-1:0] held_reg, held_next;
    logic [rdq_pkg::KEY_W-1:0] key_reg, key_next;
    logic [IW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] rem_reg, rem_next;
    logic cmp_vld_reg, cmp_vld_next;

    logic done_reg, done_next;
    logic [rdq_pkg::STATUS_W-1:0] status_reg, status_next;
    logic found_reg, found_next;
    logic [rdq_pkg::KEY_W-1:0] key_out_reg, key_out_next;
    logic [rdq_pkg::PAY_W-1:0] payload_out_reg, payload_out_next;
    logic [rdq_pkg::COUNT_W-1:0] count_reg, count_next;

    logic wr_en;
    logic [IW-1:0] wr_addr;
    rdq_pkg::rec_t wr_data;
    logic rd_en;
    logic [IW-1:0] rd_addr;
    rdq_pkg::rec_t rd_data;
    logic [CW-1:0] held_m1;

    function automatic logic [IW-1:0] slot_add(input logic [IW-1:0] base,
                                               input logic [IW-1:0] off);
        logic [IW:0] sum;
        begin
            sum = {1'b0, base} + {1'b0, off};
            if (sum >= DEPTH_W)
            begin
                sum = sum - DEPTH_W;
            end
            return sum[IW-1:0];
        end
    endfunction

    rdq_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign wr_data.key     = key;
    assign wr_data.payload = payload;
    assign held_m1 = held_reg - CW'(1);

    always_comb
    begin
        state_next       = state_reg;
        front_next       = front_reg;
        held_next        = held_reg;
        key_next         = key_reg;
        ptr_next         = ptr_reg;
        rem_next         = rem_reg;
        cmp_vld_next     = 1'b0;
        done_next        = 1'b0;
        status_next      = status_reg;
        found_next       = found_reg;
        key_out_next     = key_out_reg;
        payload_out_next = payload_out_reg;
        count_next       = count_reg;
        wr_en            = 1'b0;
        wr_addr          = front_reg;
        rd_en            = 1'b0;
        rd_addr          = ptr_reg;

        case (state_reg)
            rdq_pkg::S_IDLE:
            begin
                if (start)
                begin
                    status_next      = rdq_pkg::STATUS_DONE;
                    found_next       = 1'b0;
                    key_out_next     = '0;
                    payload_out_next = '0;
                    case (cmd)
                        rdq_pkg::CMD_PUSH_FRONT, rdq_pkg::CMD_PUSH_BACK:
                        begin
                            done_next = 1'b1;
                            if (held_reg == DEPTH_C)
                            begin
                                status_next = rdq_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                wr_en = 1'b1;
                                if (cmd == rdq_pkg::CMD_PUSH_FRONT)
                                begin
                                    wr_addr    = slot_add(front_reg, IW'(DEPTH - 1));
                                    front_next = wr_addr;
                                end
                                else
                                begin
                                    wr_addr = slot_add(front_reg, held_reg[IW-1:0]);
                                end
                                held_next = held_reg + CW'(1);
                            end
                        end
                        rdq_pkg::CMD_POP_FRONT, rdq_pkg::CMD_POP_BACK:
                        begin
                            if (held_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = rdq_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                rd_en = 1'b1;
                                if (cmd == rdq_pkg::CMD_POP_FRONT)
                                begin
                                    rd_addr    = front_reg;
                                    front_next = slot_add(front_reg, IW'(1));
                                end
                                else
                                begin
                                    rd_addr = slot_add(front_reg, held_m1[IW-1:0]);
                                end
                                held_next  = held_m1;
                                state_next = rdq_pkg::S_POP;
                            end
                        end
                        rdq_pkg::CMD_SEARCH:
                        begin
                            if (held_reg == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                key_next   = key;
                                ptr_next   = front_reg;
                                rem_next   = held_reg;
                                state_next = rdq_pkg::S_SEARCH;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                    count_next = rdq_pkg::COUNT_W'(held_next);
                end
            end
            rdq_pkg::S_POP:
            begin
                done_next        = 1'b1;
                key_out_next     = rd_data.key;
                payload_out_next = rd_data.payload;
                state_next       = rdq_pkg::S_IDLE;
            end
            rdq_pkg::S_SEARCH:
            begin
                if (cmp_vld_reg && (rd_data.key == key_reg))
                begin
                    done_next  = 1'b1;
                    found_next = 1'b1;
                    state_next = rdq_pkg::S_IDLE;
                end
                else if (rem_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = rdq_pkg::S_IDLE;
                end
                else
                begin
                    rd_en        = 1'b1;
                    rd_addr      = ptr_reg;
                    ptr_next     = slot_add(ptr_reg, IW'(1));
                    rem_next     = rem_reg - CW'(1);
                    cmp_vld_next = 1'b1;
                end
            end
            default:
            begin
                state_next = rdq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= rdq_pkg::S_IDLE;
            front_reg       <= '0;
            held_reg        <= '0;
            rem_reg         <= '0;
            cmp_vld_reg     <= 1'b0;
            done_reg        <= 1'b0;
            status_reg      <= rdq_pkg::STATUS_DONE;
            found_reg       <= 1'b0;
            key_out_reg     <= '0;
            payload_out_reg <= '0;
            count_reg       <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            front_reg       <= front_next;
            held_reg        <= held_next;
            rem_reg         <= rem_next;
            cmp_vld_reg     <= cmp_vld_next;
            done_reg        <= done_next;
            status_reg      <= status_next;
            found_reg       <= found_next;
            key_out_reg     <= key_out_next;
            payload_out_reg <= payload_out_next;
            count_reg       <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        ptr_reg <= ptr_next;
    end

    assign busy        = (state_reg != rdq_pkg::S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign found       = found_reg;
    assign key_out     = key_out_reg;
    assign payload_out = payload_out_reg;
    assign count       = count_reg;

endmodule
